// ===== rtl/lrukv_pkg.sv =====
package lrukv_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int DATA_W           = 32;
  localparam int CFG_W            = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the request and restart the search
    logic scan;      // issue the key read at the scan address
    logic resolve;   // apply the hit, insert or evict decision
    logic out_load;  // move the result into the output register
  } lrukv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last; // the scan address is the last slot
    logic out_free;  // the output register can take a result this cycle
  } lrukv_stat_t;

endpackage

// ===== rtl/lrukv_ctrl.sv =====
module lrukv_ctrl
  import lrukv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lrukv_stat_t stat,
  output lrukv_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_CHECK   = 5'b00100,
    ST_RESOLVE = 5'b01000,
    ST_DELIVER = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_CHECK;
        end
      end
      // The last key read is compared here.
      ST_CHECK: begin
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lrukv_dp.sv =====
module lrukv_dp
  import lrukv_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_req_type,
  input  logic signed [DATA_W-1:0] in_lookup_key,
  input  logic signed [DATA_W-1:0] in_write_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic signed [DATA_W-1:0] out_read_value,
  input  lrukv_cmd_t               cmd,
  output lrukv_stat_t              stat
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Key and value stores.
  logic [DATA_W-1:0] key_mem [CAPACITY];
  logic [DATA_W-1:0] val_mem [CAPACITY];

  // Per-slot state.
  logic             valid_r [CAPACITY];
  logic [IDX_W-1:0] rank_r  [CAPACITY];
  logic [CNT_W-1:0] count_r;
  logic [CFG_W-1:0] cap_r;

  // Request.
  logic              put_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] wval_r;

  // Search.
  logic [IDX_W-1:0]  scan_addr_r;
  logic              cmp_en_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [DATA_W-1:0] key_rd_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [IDX_W-1:0]  hit_rank_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [IDX_W-1:0]  victim_idx_r;
  logic [DATA_W-1:0] val_rd_r;

  // Output register.
  logic              out_valid_r;
  logic              out_found_r;
  logic [DATA_W-1:0] out_value_r;

  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_rank;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_lim;
  logic [CMP_W-1:0] eff_cap;
  logic             do_insert;
  logic             do_update;
  logic [IDX_W-1:0] tgt_idx;
  logic [CNT_W-1:0] age_below;

  assign cmp_valid = valid_r[cmp_idx_r];
  assign cmp_rank  = rank_r[cmp_idx_r];

  assign stat.scan_last = (scan_addr_r == IDX_W'(CAPACITY - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // A register value of zero counts as one; values above the store size are clamped.
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    cap_lim = CMP_W'(CAPACITY);
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > cap_lim) begin
      eff_cap = cap_lim;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Entries whose rank is below age_below age by one; the target slot becomes rank 0.
  // An insert ages every held entry, an eviction reuses the least recent slot.
  always_comb begin
    do_insert = put_r && !hit_r && (CMP_W'(count_r) < eff_cap);
    do_update = hit_r || put_r;
    if (hit_r) begin
      tgt_idx   = hit_idx_r;
      age_below = CNT_W'(hit_rank_r);
    end else if (do_insert) begin
      tgt_idx   = free_idx_r;
      age_below = count_r;
    end else begin
      tgt_idx   = victim_idx_r;
      age_below = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      key_rd_r <= key_mem[scan_addr_r];
    end
    if (cmd.resolve && put_r && !hit_r) begin
      key_mem[tgt_idx] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      val_rd_r <= val_mem[hit_idx_r];
      if (put_r) begin
        val_mem[tgt_idx] <= wval_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      put_r  <= (in_req_type == REQ_PUT);
      key_r  <= in_lookup_key;
      wval_r <= in_write_value;
    end
    if (cmd.scan) begin
      cmp_idx_r <= scan_addr_r;
    end
    if (cmp_en_r) begin
      if (cmp_valid && key_rd_r == key_r) begin
        hit_idx_r  <= cmp_idx_r;
        hit_rank_r <= cmp_rank;
      end
      if (!cmp_valid && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
      if (cmp_valid && CNT_W'(cmp_rank) == count_r - CNT_W'(1)) begin
        victim_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.out_load) begin
      out_found_r <= hit_r;
      out_value_r <= (!put_r && hit_r) ? val_rd_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r  <= '0;
      cmp_en_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.capture) begin
        scan_addr_r  <= '0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmd.scan) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end
      if (cmp_en_r) begin
        if (cmp_valid && key_rd_r == key_r) begin
          hit_r <= 1'b1;
        end
        if (!cmp_valid) begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd.resolve && do_insert) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end else if (cmd.resolve && do_update) begin
        if (tgt_idx == IDX_W'(i)) begin
          valid_r[i] <= 1'b1;
          rank_r[i]  <= '0;
        end else if (valid_r[i] && CNT_W'(rank_r[i]) < age_below) begin
          rank_r[i] <= rank_r[i] + IDX_W'(1);
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Channel | Ports                                        | Beat taken when
// --------+----------------------------------------------+----------------------
// in      | in_req_type, in_lookup_key, in_write_value   | in_valid && in_ready
// out     | out_found, out_read_value                    | out_valid && out_ready
// cfg     | cfg_wdata (capacity in use)                  | cfg_we
//
// A request scans the key memory one slot a cycle, then passes the check and resolve
// states; its result is loaded when the output register is free.
// One request is in flight at a time; the output register lets a new request enter
// while the previous result waits for out_ready.
// Synchronous active-low reset empties the cache and sets the capacity in use to 16.
module lru_key_value_cache
  import lrukv_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [DATA_W-1:0] in_lookup_key,
  input  logic signed [DATA_W-1:0] in_write_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic signed [DATA_W-1:0] out_read_value
);

  lrukv_cmd_t  cmd;
  lrukv_stat_t stat;

  lrukv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrukv_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule
